// ----- sv/nodata_aware_two_by_two_downsample_unit_assert.svh -----
// Assertion macros shared by the downsample unit modules.
`ifndef NODATA_AWARE_TWO_BY_TWO_DOWNSAMPLE_UNIT_ASSERT_SVH
`define NODATA_AWARE_TWO_BY_TWO_DOWNSAMPLE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define NDDS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ndds assertion failed");

// Next-cycle implication.
`define NDDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ndds assertion failed");

`endif

// ----- sv/ndds_pkg.sv -----
// Package: constants, codes and stage types of the downsample unit.
`timescale 1ns / 1ps
package ndds_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int IDX_W      = $clog2(MAX_WIDTH);
   localparam int POS_W      = 12;
   localparam int DIM_W      = 13;
   localparam int DATA_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef logic signed [DATA_W-1:0] sample_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_WIDTH,
      CSR_SOURCE_HEIGHT,
      CSR_MISSING_VALUE,
      CSR_MISSING_CHECK_ON
   } csr_index_type;

   // How the output pixel is formed from what the request sees.
   typedef enum logic [1:0] {
      KIND_BLOCK,     // full 2x2 block
      KIND_ROW_PAIR,  // odd last row: left + current
      KIND_COL_PAIR,  // odd last column: above + current
      KIND_COPY       // odd corner
   } kind_type;

   typedef struct packed {
      logic       check_on;
      sample_type value;
   } missing_cfg_type;

   typedef struct packed {
      kind_type   kind;
      logic       emit;
      logic       done;
      logic       odd_row;
      sample_type sample;
      sample_type left;
   } stage1_type;

   typedef struct packed {
      kind_type   kind;
      logic       done;
      logic       top_none;
      logic       bot_none;
      sample_type top;
      sample_type bot;
      sample_type corner;
      sample_type sample;
   } stage2_type;

endpackage

// ----- sv/ndds_channels_if.sv -----
// Request and response channel interfaces of the downsample unit.
`timescale 1ns / 1ps
interface ndds_req_if;
   import ndds_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface ndds_rsp_if;
   import ndds_pkg::*;
   logic       valid;
   logic       ready;
   sample_type reduced_pixel;
   logic       level_done;
   modport source (output valid, output reduced_pixel, output level_done, input ready);
   modport sink (input valid, input reduced_pixel, input level_done, output ready);
endinterface

// ----- sv/ndds_line_store.sv -----
// Even-row line store: one write or one registered read per cycle.
`timescale 1ns / 1ps
module ndds_line_store (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [ndds_pkg::IDX_W-1:0] addr,
   input  ndds_pkg::sample_type     wdata,
   output ndds_pkg::sample_type     rd_data
);
   import ndds_pkg::*;

   sample_type line_ff [MAX_WIDTH];
   sample_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         line_ff[addr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= line_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/ndds_ctrl.sv -----
// Control: CSRs, raster position, line store access and first stage register.
`timescale 1ns / 1ps
`include "nodata_aware_two_by_two_downsample_unit_assert.svh"
module ndds_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ndds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ndds_pkg::CSR_DATA_W-1:0] csr_wdata,
   ndds_req_if.sink                        req_chan,
   input  logic                            s1_free,
   output logic                            s1_valid,
   output ndds_pkg::stage1_type            s1,
   output ndds_pkg::missing_cfg_type       missing_cfg,
   output logic                            mem_we,
   output logic                            mem_re,
   output logic [ndds_pkg::IDX_W-1:0]      mem_addr,
   output ndds_pkg::sample_type            mem_wdata
);
   import ndds_pkg::*;

   logic [DIM_W-1:0] width_ff, height_ff;
   sample_type       miss_value_ff;
   logic             check_on_ff;

   logic [POS_W-1:0] col_ff, row_ff;
   logic [POS_W-1:0] col_in, row_in;
   sample_type       left_ff;
   logic             s1_valid_ff, s1_valid_in;
   stage1_type       s1_ff, s1_in;

   logic [DIM_W-1:0] w_eff, h_eff, col_next, row_next;
   logic             last_col, last_row, odd_col, odd_row, accept;

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= DIM_W'(1);
         height_ff     <= DIM_W'(1);
         miss_value_ff <= '0;
         check_on_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SOURCE_WIDTH:     width_ff      <= csr_wdata[DIM_W-1:0];
            CSR_SOURCE_HEIGHT:    height_ff     <= csr_wdata[DIM_W-1:0];
            CSR_MISSING_VALUE:    miss_value_ff <= csr_wdata[DATA_W-1:0];
            CSR_MISSING_CHECK_ON: check_on_ff   <= csr_wdata[0];
         endcase
      end
   end

   assign missing_cfg.check_on = check_on_ff;
   assign missing_cfg.value    = miss_value_ff;

   always_comb begin
      // zero counts as 1, oversize as the maximum
      w_eff = width_ff;
      if (width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (width_ff > DIM_W'(MAX_WIDTH)) begin
         w_eff = DIM_W'(MAX_WIDTH);
      end
      h_eff = height_ff;
      if (height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (height_ff > DIM_W'(MAX_HEIGHT)) begin
         h_eff = DIM_W'(MAX_HEIGHT);
      end

      col_next = {1'b0, col_ff} + DIM_W'(1);
      row_next = {1'b0, row_ff} + DIM_W'(1);
      last_col = col_next >= w_eff;
      last_row = row_next >= h_eff;
      odd_col  = col_ff[0];
      odd_row  = row_ff[0];

      accept         = req_chan.valid && s1_free;
      req_chan.ready = s1_free;

      s1_in.sample  = req_chan.sample;
      s1_in.left    = left_ff;
      s1_in.odd_row = odd_row;
      s1_in.done    = last_col && last_row;
      if (!odd_row) begin
         s1_in.emit = last_row && (odd_col || last_col);
         s1_in.kind = odd_col ? KIND_ROW_PAIR : KIND_COPY;
      end else begin
         s1_in.emit = odd_col || last_col;
         s1_in.kind = odd_col ? KIND_BLOCK : KIND_COL_PAIR;
      end

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_next[POS_W-1:0];
         end else begin
            col_in = col_next[POS_W-1:0];
         end
      end

      s1_valid_in = accept || (s1_valid_ff && !s1_free);

      mem_we    = accept && !odd_row;
      mem_re    = accept && odd_row;
      mem_addr  = col_ff[IDX_W-1:0];
      mem_wdata = req_chan.sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         left_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            left_ff <= req_chan.sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1       = s1_ff;

   `NDDS_ASSERT_NEXT(a_col_wrap, clock, reset, accept && last_col, col_ff == '0)
   `NDDS_ASSERT_NEXT(a_row_wrap, clock, reset, accept && last_col && last_row, row_ff == '0)

endmodule

// ----- sv/ndds_reduce.sv -----
// Reduction datapath: pair averages, block average and output register.
`timescale 1ns / 1ps
`include "nodata_aware_two_by_two_downsample_unit_assert.svh"
module ndds_reduce (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      s1_valid,
   input  ndds_pkg::stage1_type      s1,
   input  ndds_pkg::sample_type      rd_data,
   input  ndds_pkg::missing_cfg_type missing_cfg,
   output logic                      s1_free,
   ndds_rsp_if.source                rsp_chan
);
   import ndds_pkg::*;

   // (a + b) / 2 over a 33-bit sum, truncated toward zero
   function automatic sample_type avg2(input sample_type a, input sample_type b);
      logic [DATA_W:0] sum;
      logic [DATA_W:0] adj;
      sum = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      adj = sum + {{DATA_W{1'b0}}, sum[DATA_W]};
      return adj[DATA_W:1];
   endfunction

   sample_type ul_ff;
   logic       s2_valid_ff, s2_valid_in;
   stage2_type s2_ff, s2_in;
   logic       out_valid_ff, out_valid_in;
   sample_type out_pixel_ff, out_pixel_in;
   logic       out_done_ff;

   sample_type a0, a1;
   logic       a0_miss, a1_miss, b0_miss, b1_miss;
   logic       s1_adv, s2_free, out_en;

   always_comb begin
      out_en  = !out_valid_ff || rsp_chan.ready;
      s2_free = !s2_valid_ff || out_en;
      // items with no pixel leave stage 1 without taking a slot downstream
      s1_adv  = s1_valid && (!s1.emit || s2_free);
      s1_free = !s1_valid || s1_adv;

      if (s1.kind == KIND_COL_PAIR) begin
         a0 = rd_data;
         a1 = s1.sample;
      end else begin
         a0 = ul_ff;
         a1 = rd_data;
      end

      a0_miss = missing_cfg.check_on && (a0 == missing_cfg.value);
      a1_miss = missing_cfg.check_on && (a1 == missing_cfg.value);
      b0_miss = missing_cfg.check_on && (s1.left == missing_cfg.value);
      b1_miss = missing_cfg.check_on && (s1.sample == missing_cfg.value);

      s2_in.kind     = s1.kind;
      s2_in.done     = s1.done;
      s2_in.top_none = a0_miss && a1_miss;
      s2_in.bot_none = b0_miss && b1_miss;
      s2_in.corner   = ul_ff;
      s2_in.sample   = s1.sample;
      if (!a0_miss && !a1_miss) begin
         s2_in.top = avg2(a0, a1);
      end else begin
         s2_in.top = a0_miss ? a1 : a0;
      end
      if (!b0_miss && !b1_miss) begin
         s2_in.bot = avg2(s1.left, s1.sample);
      end else begin
         s2_in.bot = b0_miss ? s1.sample : s1.left;
      end

      s2_valid_in = (s1_adv && s1.emit) || (s2_valid_ff && !out_en);

      unique case (s2_ff.kind)
         KIND_BLOCK: begin
            priority if (!s2_ff.top_none && !s2_ff.bot_none) begin
               out_pixel_in = avg2(s2_ff.top, s2_ff.bot);
            end else if (s2_ff.top_none && s2_ff.bot_none) begin
               out_pixel_in = s2_ff.corner;
            end else begin
               out_pixel_in = s2_ff.top_none ? s2_ff.bot : s2_ff.top;
            end
         end
         KIND_ROW_PAIR: out_pixel_in = s2_ff.bot;
         KIND_COL_PAIR: out_pixel_in = s2_ff.top;
         KIND_COPY:     out_pixel_in = s2_ff.sample;
      endcase

      out_valid_in = out_en ? s2_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ul_ff        <= '0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_adv && s1.odd_row) begin
            ul_ff <= rd_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1.emit) begin
         s2_ff <= s2_in;
      end
      if (out_en && s2_valid_ff) begin
         out_pixel_ff <= out_pixel_in;
         out_done_ff  <= s2_ff.done;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.reduced_pixel = out_pixel_ff;
   assign rsp_chan.level_done    = out_done_ff;

   `NDDS_ASSERT_NEXT(a_s2_hold, clock, reset, s2_valid_ff && !out_en, s2_valid_ff && $stable(s2_ff))
   `NDDS_ASSERT_NOW(a_s1_no_overrun, clock, reset, s1_valid && s1.emit && !s2_free, !s1_free)

endmodule

// ----- sv/nodata_aware_two_by_two_downsample_unit.sv -----
// Top level of the no-data aware 2x2 mipmap downsample unit.
//
//   channel   | dir | handshake     | payload
//   ----------+-----+---------------+-----------------------------------
//   req_chan  | in  | valid / ready | sample (s32)
//   rsp_chan  | out | valid / ready | reduced_pixel (s32), level_done
//   csr_*     | in  | csr_we        | csr_index (2b), csr_wdata (32b)
//
// One request per cycle while stage 1 is free; the request that completes a
// block reaches the response through line store read, pair stage, block stage.
// Throughput is set by the single-port even-row line store: one write on an
// even row or one read on an odd row per request.
// Reset is synchronous and active high; positions, holds and CSRs clear, the
// line store keeps its contents (no clearing pass).
// A stalled response only back-pressures requests once the pipeline is full;
// requests that produce no pixel keep flowing while a response waits.
`timescale 1ns / 1ps
module nodata_aware_two_by_two_downsample_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ndds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ndds_pkg::CSR_DATA_W-1:0] csr_wdata,
   ndds_req_if.sink                        req_chan,
   ndds_rsp_if.source                      rsp_chan
);
   import ndds_pkg::*;

   logic             s1_free;
   logic             s1_valid;
   stage1_type       s1;
   missing_cfg_type  missing_cfg;
   logic             mem_we, mem_re;
   logic [IDX_W-1:0] mem_addr;
   sample_type       mem_wdata;
   sample_type       rd_data;

   // raster position, CSRs and the request-side stage
   ndds_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_chan    (req_chan),
      .s1_free     (s1_free),
      .s1_valid    (s1_valid),
      .s1          (s1),
      .missing_cfg (missing_cfg),
      .mem_we      (mem_we),
      .mem_re      (mem_re),
      .mem_addr    (mem_addr),
      .mem_wdata   (mem_wdata)
   );

   // even rows are written here and read back on the following odd row
   ndds_line_store u_line_store (
      .clock   (clock),
      .we      (mem_we),
      .re      (mem_re),
      .addr    (mem_addr),
      .wdata   (mem_wdata),
      .rd_data (rd_data)
   );

   // pair / block averaging and the response register
   ndds_reduce u_reduce (
      .clock       (clock),
      .reset       (reset),
      .s1_valid    (s1_valid),
      .s1          (s1),
      .rd_data     (rd_data),
      .missing_cfg (missing_cfg),
      .s1_free     (s1_free),
      .rsp_chan    (rsp_chan)
   );

endmodule

// ----- tb/ndds_pixel_checker.sv -----
// Checker for the downsample unit: mirrors the reduction and compares responses.
`timescale 1ns / 1ps
module ndds_pixel_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ndds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ndds_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  ndds_pkg::sample_type            req_sample,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  ndds_pkg::sample_type            rsp_pixel,
   input  logic                            rsp_done,
   input  logic                            end_of_test,
   output int                              mismatch_count,
   output int                              pixels_pending
);
   import ndds_pkg::*;

   typedef struct packed {
      sample_type pixel;
      logic       done;
   } reduced_type;

   // Mirrored CSRs
   logic [DIM_W-1:0] width_reg;
   logic [DIM_W-1:0] height_reg;
   sample_type       nodata_reg;
   logic             check_reg;

   // Mirrored datapath state
   sample_type  row_store [MAX_WIDTH];
   int unsigned col_pos;
   int unsigned row_pos;
   sample_type  left_hold;
   sample_type  corner_hold;

   reduced_type expected_pixels [$];
   reduced_type want;
   int          pixel_number;
   bit          leftover_checked = 1'b0;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic logic sample_blank(input sample_type v);
      return check_reg && (v == nodata_reg);
   endfunction

   // 33-bit sum, halved with truncation toward zero
   function automatic sample_type mean2(input sample_type a, input sample_type b);
      logic signed [DATA_W:0] total;
      total = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      total = total / 2;
      return total[DATA_W-1:0];
   endfunction

   function automatic sample_type pair_mean(input sample_type a, input sample_type b,
                                            output logic both_gone);
      logic a_gone;
      logic b_gone;
      a_gone    = sample_blank(a);
      b_gone    = sample_blank(b);
      both_gone = a_gone && b_gone;
      if (!a_gone && !b_gone)
         return mean2(a, b);
      return a_gone ? b : a;
   endfunction

   function automatic sample_type block_mean(input sample_type ul, input sample_type ur,
                                             input sample_type ll, input sample_type lr);
      logic       top_gone;
      logic       bot_gone;
      sample_type top_px;
      sample_type bot_px;
      top_px = pair_mean(ul, ur, top_gone);
      bot_px = pair_mean(ll, lr, bot_gone);
      if (!top_gone && !bot_gone)
         return mean2(top_px, bot_px);
      if (top_gone && bot_gone)
         return ul;
      return top_gone ? bot_px : top_px;
   endfunction

   function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v,
                                             input int unsigned ceiling);
      if (v == 0)
         return 1;
      return (v > ceiling) ? ceiling : v;
   endfunction

   task automatic predict_sample(input sample_type s);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      int unsigned idx;
      logic        last_col;
      logic        last_row;
      logic        odd_col;
      logic        emit;
      logic        pair_gone;
      sample_type  px;
      sample_type  above;
      reduced_type item;
      w        = clamp_dim(width_reg, MAX_WIDTH);
      h        = clamp_dim(height_reg, MAX_HEIGHT);
      c        = col_pos;
      r        = row_pos;
      idx      = c % MAX_WIDTH;
      last_col = (c + 1 >= w);
      last_row = (r + 1 >= h);
      odd_col  = c[0];
      emit     = 1'b0;
      px       = '0;
      if (r[0] == 1'b0) begin
         if (last_row) begin
            if (odd_col) begin
               px   = pair_mean(left_hold, s, pair_gone);
               emit = 1'b1;
            end else if (last_col) begin
               px   = s;
               emit = 1'b1;
            end
         end
         row_store[idx] = s;
      end else begin
         above = row_store[idx];
         if (odd_col) begin
            px   = block_mean(corner_hold, above, left_hold, s);
            emit = 1'b1;
         end else if (last_col) begin
            px   = pair_mean(above, s, pair_gone);
            emit = 1'b1;
         end
         corner_hold = above;
      end
      left_hold = s;
      if (emit) begin
         item.pixel = px;
         item.done  = last_col && last_row;
         expected_pixels.insert(expected_pixels.size(), item);
      end
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : ((r + 1) & 12'hFFF);
      end else begin
         col_pos = (c + 1) & 12'hFFF;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg      = DIM_W'(1);
         height_reg     = DIM_W'(1);
         nodata_reg     = '0;
         check_reg      = 1'b0;
         col_pos        = 0;
         row_pos        = 0;
         left_hold      = '0;
         corner_hold    = '0;
         pixel_number   = 0;
         mismatch_count = 0;
         expected_pixels.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SOURCE_WIDTH:     width_reg  = csr_wdata[DIM_W-1:0];
               CSR_SOURCE_HEIGHT:    height_reg = csr_wdata[DIM_W-1:0];
               CSR_MISSING_VALUE:    nodata_reg = csr_wdata[DATA_W-1:0];
               CSR_MISSING_CHECK_ON: check_reg  = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            predict_sample(req_sample);
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("pixel %0d (value %0d) with no request behind it",
                                         pixel_number, rsp_pixel));
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel !== want.pixel)
                  report_mismatch($sformatf("pixel %0d: reduced_pixel %0d, expected %0d",
                                            pixel_number, rsp_pixel, want.pixel));
               if (rsp_done !== want.done)
                  report_mismatch($sformatf("pixel %0d: level_done %b, expected %b",
                                            pixel_number, rsp_done, want.done));
            end
            pixel_number++;
         end
         if (end_of_test && !leftover_checked) begin
            leftover_checked = 1'b1;
            if (expected_pixels.size() != 0)
               report_mismatch($sformatf("%0d expected pixels never came out",
                                         expected_pixels.size()));
         end
      end
      pixels_pending <= expected_pixels.size();
   end

endmodule

// ----- tb/tb_nodata_aware_two_by_two_downsample_unit.sv -----
// Testbench top: request stimulus, response back-pressure and verdict for the downsample unit.
`timescale 1ns / 1ps
module tb_nodata_aware_two_by_two_downsample_unit;
   import ndds_pkg::*;

   localparam int RANDOM_REQUESTS = 400;
   localparam int HOLD_CYCLES     = 300;   // one long response stall
   localparam int IDLE_LIMIT      = 2000;  // cycles with no handshake at all
   localparam int SETTLE_CYCLES   = 8;     // pipeline is 3 deep; margin on top

   localparam sample_type S_MAX = 32'sh7FFF_FFFF;
   localparam sample_type S_MIN = 32'sh8000_0000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  end_of_test;
   int                    mismatch_count;
   int                    pixels_pending;

   ndds_req_if req_chan ();
   ndds_rsp_if rsp_chan ();

   // stimulus-side view of the no-data setup, used to aim samples at it
   sample_type cur_nodata;
   logic       cur_check;
   int         burst_left = 0;
   sample_type level_q [$];

   // receiver state
   logic       hold_request;
   bit         hold_taken = 1'b0;
   int         hold_left  = 0;
   int         stall_mode = 0;
   int         mode_left  = 0;
   int         quiet_cycles = 0;

   always #5 clock = ~clock;

   nodata_aware_two_by_two_downsample_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   ndds_pixel_checker u_pixel_check (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_sample     (req_chan.sample),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_pixel      (rsp_chan.reduced_pixel),
      .rsp_done       (rsp_chan.level_done),
      .end_of_test    (end_of_test),
      .mismatch_count (mismatch_count),
      .pixels_pending (pixels_pending)
   );

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // One CSR write; the trailing wait with csr_we low keeps back-to-back calls from
   // driving csr_we twice in one step.
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure_level(input int w, input int h, input sample_type nodata,
                                  input logic check_on);
      write_csr(CSR_SOURCE_WIDTH, CSR_DATA_W'(w));
      write_csr(CSR_SOURCE_HEIGHT, CSR_DATA_W'(h));
      write_csr(CSR_MISSING_VALUE, nodata);
      write_csr(CSR_MISSING_CHECK_ON, CSR_DATA_W'(check_on));
      cur_nodata = nodata;
      cur_check  = check_on;
   endtask

   // Offer one request and hold it until accepted. The sender runs in
   // bursts; a gap may open before a new burst starts.
   task automatic push_sample(input sample_type s);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_chan.valid  <= 1'b1;
      req_chan.sample <= s;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      burst_left--;
   endtask

   // Wait for every predicted pixel, then let requests that make no pixel
   // drain out of the pipeline before touching the CSRs.
   task automatic settle();
      @(posedge clock);
      while (pixels_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mix of no-data hits, extremes, small values (exercise rounding) and
   // full-range noise.
   function automatic sample_type pick_sample();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 30)
         return cur_nodata;
      if (roll < 40) begin
         case ($urandom_range(0, 3))
            0: return S_MIN;
            1: return S_MAX;
            2: return -1;
            default: return 0;
         endcase
      end
      if (roll < 65)
         return $urandom_range(0, 200) - 100;
      return $urandom;
   endfunction

   function automatic sample_type pick_nodata();
      case ($urandom_range(0, 5))
         0: return S_MIN;
         1: return S_MAX;
         2: return 0;
         3: return -1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_level(input int count);
      repeat (count) push_sample(pick_sample());
      req_chan.valid <= 1'b0;
      settle();
   endtask

   task automatic send_pattern();
      foreach (level_q[i]) push_sample(level_q[i]);
      req_chan.valid <= 1'b0;
      settle();
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      sample_type nd;
      int         w_reg;
      int         h_reg;
      int         count;
      int         random_sent;

      csr_we          = 1'b0;
      csr_index       = CSR_SOURCE_WIDTH;
      csr_wdata       = '0;
      req_chan.valid  = 1'b0;
      req_chan.sample = '0;
      end_of_test     = 1'b0;
      hold_request    = 1'b0;
      cur_nodata      = '0;
      cur_check       = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry is 1x1: a lone request is the odd corner, copied.
      level_q = '{S_MAX};
      send_pattern();

      // Zero width and height behave as 1.
      configure_level(0, 0, S_MAX, 1'b1);
      level_q = '{S_MAX};
      send_pattern();

      // Single row, checking off: horizontal pairs at the extremes; the
      // second pair is negative and odd, so it truncates toward zero.
      configure_level(4, 1, '0, 1'b0);
      level_q = '{S_MAX, S_MAX, S_MIN, -32'sd3};
      send_pattern();

      // 3x3 with no-data -7: fully missing block copies top-left, fully
      // missing pair on the last column copies its partner, odd last row
      // replaces a missing sample, odd corner copied.
      nd = -7;
      configure_level(3, 3, nd, 1'b1);
      level_q = '{nd, nd, nd,
                  nd, nd, nd,
                  32'sd4, nd, 32'sd9};
      send_pattern();

      // 6x2: one missing in the top pair, whole bottom pair missing, whole top
      // pair missing.
      configure_level(6, 2, nd, 1'b1);
      level_q = '{nd, 32'sd6, 32'sd5, 32'sd7, nd, nd,
                  32'sd8, -32'sd9, nd, nd, -32'sd5, nd};
      send_pattern();

      // Back-pressure: the receiver stalls for a long stretch while the
      // sender keeps offering, so the pipeline fills and stops requests.
      random_sent = 0;
      hold_request <= 1'b1;
      configure_level(16, 12, pick_nodata(), 1'b1);
      send_level(16 * 12);
      random_sent += 16 * 12;

      // Random small levels with random no-data setup.
      while (random_sent < RANDOM_REQUESTS) begin
         w_reg = $urandom_range(0, 10);
         h_reg = $urandom_range(0, 8);
         configure_level(w_reg, h_reg, pick_nodata(), $urandom_range(0, 3) != 0);
         count = (w_reg == 0 ? 1 : w_reg) * (h_reg == 0 ? 1 : h_reg);
         send_level(count);
         random_sent += count;
      end

      // Height shrinks mid-level while on an even row: that row becomes the
      // last one, the level closes early and positions wrap.
      configure_level(6, 6, pick_nodata(), 1'b1);
      send_level(15);
      write_csr(CSR_SOURCE_HEIGHT, CSR_DATA_W'(2));
      send_level(3);

      end_of_test <= 1'b1;
      repeat (2) @(posedge clock);
      if (mismatch_count == 0)
         $display("nodata_aware_two_by_two_downsample_unit test passed");
      else
         $display("nodata_aware_two_by_two_downsample_unit test failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver: stall pattern switches between modes at random intervals;
   // one long hold-off on request from the stimulus.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 96);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_chan.ready <= 1'b1;                            // never stalls
            1: rsp_chan.ready <= $urandom_range(0, 1);            // coin flip
            2: rsp_chan.ready <= ($urandom_range(0, 3) == 0);     // mostly stalled
            default: rsp_chan.ready <= ($urandom_range(0, 7) != 0); // rare stall
         endcase
      end
   end

   // Initial value for the receiver before the first edge.
   initial rsp_chan.ready = 1'b0;

   // ---------------------------------------------------------------------
   // Watchdog: ends the run if no request or response moves for too long.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("nodata_aware_two_by_two_downsample_unit test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/ndds_pkg.sv
sv/ndds_channels_if.sv
sv/ndds_line_store.sv
sv/ndds_ctrl.sv
sv/ndds_reduce.sv
sv/nodata_aware_two_by_two_downsample_unit.sv
tb/ndds_pixel_checker.sv
tb/tb_nodata_aware_two_by_two_downsample_unit.sv
